### rtl/kscc_pkg.sv
// Shared types, constants and register indexes of the knob setpoint controller.
`default_nettype none

package kscc_pkg;

   localparam int LEVEL_W  = 10;
   localparam int GAIN_W   = 4;
   localparam int COUNT_W  = 16;
   localparam int VALUE_W  = 13;
   localparam int CSR_W    = 16;
   localparam int CSR_A_W  = 2;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam logic [VALUE_W-1:0] VALUE_MAX = 13'h1FFF;

   localparam logic [LEVEL_W-1:0] INITIAL_LEVEL_RESET = 10'd550;
   localparam logic [LEVEL_W-1:0] MAX_LEVEL_RESET     = 10'd1023;
   localparam logic [GAIN_W-1:0]  OUTPUT_GAIN_RESET   = 4'd2;
   localparam logic [COUNT_W-1:0] FORWARD_STEP_RESET  = 16'd4;

   localparam logic FUNC_TICK    = 1'b0;
   localparam logic FUNC_ENCODER = 1'b1;

   localparam logic KIND_DRIVE = 1'b0;
   localparam logic KIND_SAVE  = 1'b1;

   typedef enum logic [CSR_A_W-1:0] {
      CSR_INITIAL_LEVEL = 2'd0,
      CSR_MAX_LEVEL     = 2'd1,
      CSR_OUTPUT_GAIN   = 2'd2,
      CSR_FORWARD_STEP  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] initial_level;
      logic [LEVEL_W-1:0] max_level;
      logic [GAIN_W-1:0]  output_gain;
      logic [COUNT_W-1:0] forward_step;
   } cfg_type;

   typedef struct packed {
      logic press;
      logic release_evt;
   } btn_evt_type;

   typedef struct packed {
      logic               kind;
      logic [VALUE_W-1:0] value;
      logic               last;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/kscc_csr.sv
// Configuration registers of the knob setpoint controller.
`default_nettype none

module kscc_csr
   import kscc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [CSR_A_W-1:0] csr_addr,
   input  wire logic [CSR_W-1:0]   csr_wdata,
   output cfg_type                 cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_INITIAL_LEVEL: cfg_in.initial_level = csr_wdata[LEVEL_W-1:0];
            CSR_MAX_LEVEL:     cfg_in.max_level     = csr_wdata[LEVEL_W-1:0];
            CSR_OUTPUT_GAIN:   cfg_in.output_gain   = csr_wdata[GAIN_W-1:0];
            CSR_FORWARD_STEP:  cfg_in.forward_step  = csr_wdata[COUNT_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.initial_level <= INITIAL_LEVEL_RESET;
         cfg_ff.max_level     <= MAX_LEVEL_RESET;
         cfg_ff.output_gain   <= OUTPUT_GAIN_RESET;
         cfg_ff.forward_step  <= FORWARD_STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### rtl/kscc_debounce.sv
// Sample history, debounced level and press/release detection for one button.
`default_nettype none

module kscc_debounce
   import kscc_pkg::*;
#(
   parameter int HISTORY_BITS = 8
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  sample_en,
   input  wire logic  pin,
   output btn_evt_type evt
);

   logic [HISTORY_BITS-1:0] hist_ff, hist_in;
   logic                    stable_ff, stable_in;
   logic                    held_ff, held_in;

   always_comb begin
      hist_in   = hist_ff;
      stable_in = stable_ff;
      held_in   = held_ff;
      evt       = '0;
      if (sample_en) begin
         hist_in = {hist_ff[HISTORY_BITS-2:0], pin};
         if (hist_in == '0) begin
            stable_in = 1'b0;
         end else if (hist_in == '1) begin
            stable_in = 1'b1;
         end
         // A low debounced level is a held button; edges of the mark are the events.
         evt.press       = !stable_in && !held_ff;
         evt.release_evt = stable_in && held_ff;
         held_in         = !stable_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff   <= '1;
         stable_ff <= 1'b1;
         held_ff   <= 1'b0;
      end else begin
         hist_ff   <= hist_in;
         stable_ff <= stable_in;
         held_ff   <= held_in;
      end
   end

endmodule

`default_nettype wire

### rtl/kscc_rsp_queue.sv
// Four-entry result queue taking up to two results a cycle and giving one.
`default_nettype none

module kscc_rsp_queue
   import kscc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [1:0] push_cnt,
   input  wire rsp_type    push_a,
   input  wire rsp_type    push_b,
   output logic            room,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output rsp_type         rsp_head
);

   rsp_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                pop;
   logic [QPTR_W-1:0]   wr_next;

   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_head   = mem_ff[rd_ff];
   assign pop        = rsp_tvalid && rsp_tready;
   // Room for a full pair of results, whatever leaves this cycle.
   assign room       = (cnt_ff <= QCNT_W'(QUEUE_DEPTH - 2));
   assign wr_next    = wr_ff + QPTR_W'(1);

   always_comb begin
      wr_in  = wr_ff + QPTR_W'(push_cnt);
      rd_in  = rd_ff + QPTR_W'(pop);
      cnt_in = cnt_ff + QCNT_W'(push_cnt) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem_ff[wr_ff] <= push_a;
      end
      if (push_cnt == 2'd2) begin
         mem_ff[wr_next] <= push_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

### rtl/knob_setpoint_controller_core.sv
// Top level of the knob setpoint controller: input register, item logic and result queue.
`default_nettype none

// An item is taken into an input register, worked on once the result queue has room by
// combinational logic (debounce, mode and level update, one 10 by 4 bit multiply)
// and its zero, one or two results are written into a four-entry result queue.
// The block accepts one item per cycle while the queue holds two results or fewer;
// the result port gives one result per cycle while rsp_tready is high, so items that each
// cause two results fill the queue and are held back even when results are drained at
// full speed. An accepted item passes the input register and the result queue before
// its first result shows on the port. The setpoint level starts at 550 after reset;
// writing initial_level later does not move it.
module knob_setpoint_controller_core
   import kscc_pkg::*;
#(
   parameter int HISTORY_BITS = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // req_tdata: pin_zero [0], pin_one [1], encoder_count [17:2], zero fill
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // req_tuser: func [0]
   input  wire logic                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // rsp_tdata: value [12:0], zero fill
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // rsp_tuser: kind [0]
   output logic                       rsp_tuser,
   output logic                       rsp_tlast,
   input  wire logic                  csr_we,
   input  wire logic [CSR_A_W-1:0]    csr_addr,
   input  wire logic [CSR_W-1:0]      csr_wdata
);

   function automatic logic [VALUE_W-1:0] drive_value(input logic [LEVEL_W-1:0] lvl,
                                                      input logic [GAIN_W-1:0]  gain);
      logic [LEVEL_W+GAIN_W-1:0] prod;
      prod = {{GAIN_W{1'b0}}, lvl} * {{LEVEL_W{1'b0}}, gain};
      if (prod > {1'b0, VALUE_MAX}) begin
         return VALUE_MAX;
      end
      return prod[VALUE_W-1:0];
   endfunction

   cfg_type cfg;

   logic               in_valid_ff, in_valid_in;
   logic               func_ff;
   logic               pin0_ff, pin1_ff;
   logic [COUNT_W-1:0] count_ff;

   logic               adjust_ff, adjust_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [COUNT_W-1:0] last_count_ff, last_count_in;

   logic               room;
   logic               fire;
   logic               tick_en;
   btn_evt_type        evt0, evt1;

   logic               emit0, emit1;
   rsp_type            res0, res1;
   logic [1:0]         push_cnt;
   rsp_type            push_a, push_b, rsp_head;

   logic [COUNT_W-1:0] diff;
   logic [LEVEL_W:0]   level_up, level_dn;

   assign fire       = in_valid_ff && room;
   assign req_tready = !in_valid_ff || fire;
   assign tick_en    = fire && (func_ff == FUNC_TICK);

   kscc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   kscc_debounce #(.HISTORY_BITS(HISTORY_BITS)) u_btn0 (
      .clock     (clock),
      .reset     (reset),
      .sample_en (tick_en),
      .pin       (pin0_ff),
      .evt       (evt0)
   );

   kscc_debounce #(.HISTORY_BITS(HISTORY_BITS)) u_btn1 (
      .clock     (clock),
      .reset     (reset),
      .sample_en (tick_en),
      .pin       (pin1_ff),
      .evt       (evt1)
   );

   assign diff     = count_ff - last_count_ff;
   assign level_up = {1'b0, level_ff} + (LEVEL_W+1)'(1);
   assign level_dn = {1'b0, level_ff} - (LEVEL_W+1)'(1);

   always_comb begin
      adjust_in     = adjust_ff;
      level_in      = level_ff;
      last_count_in = last_count_ff;
      emit0         = 1'b0;
      emit1         = 1'b0;
      res0          = '0;
      res1          = '0;
      if (fire) begin
         if (func_ff == FUNC_TICK) begin
            // Button 0 gives a drive command, button 1 a possible save request.
            emit0      = evt0.press || evt0.release_evt;
            res0.kind  = KIND_DRIVE;
            res0.value = evt0.press ? drive_value(level_ff, cfg.output_gain) : '0;
            if (evt1.press) begin
               emit1      = adjust_ff;
               res1.kind  = KIND_SAVE;
               res1.value = {{(VALUE_W-LEVEL_W){1'b0}}, level_ff};
               adjust_in  = !adjust_ff;
            end
         end else begin
            last_count_in = count_ff;
            if (adjust_ff) begin
               if (diff == cfg.forward_step) begin
                  if (level_up <= {1'b0, cfg.max_level}) begin
                     level_in = level_up[LEVEL_W-1:0];
                  end
               end else if (level_ff != '0 && level_dn <= {1'b0, cfg.max_level}) begin
                  level_in = level_dn[LEVEL_W-1:0];
               end
               emit0      = 1'b1;
               res0.kind  = KIND_DRIVE;
               res0.value = drive_value(level_in, cfg.output_gain);
            end
         end
      end
   end

   always_comb begin
      push_a = res0;
      push_b = res1;
      push_b.last = 1'b1;
      if (emit0 && emit1) begin
         push_cnt    = 2'd2;
         push_a.last = 1'b0;
      end else if (emit0) begin
         push_cnt    = 2'd1;
         push_a.last = 1'b1;
      end else if (emit1) begin
         push_cnt    = 2'd1;
         push_a      = res1;
         push_a.last = 1'b1;
      end else begin
         push_cnt    = 2'd0;
      end
   end

   kscc_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_cnt   (push_cnt),
      .push_a     (push_a),
      .push_b     (push_b),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_head   (rsp_head)
   );

   assign rsp_tdata = {{(RSP_DATA_W-VALUE_W){1'b0}}, rsp_head.value};
   assign rsp_tuser = rsp_head.kind;
   assign rsp_tlast = rsp_head.last;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         func_ff  <= req_tuser;
         pin0_ff  <= req_tdata[0];
         pin1_ff  <= req_tdata[1];
         count_ff <= req_tdata[COUNT_W+1:2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         adjust_ff     <= 1'b0;
         level_ff      <= INITIAL_LEVEL_RESET;
         last_count_ff <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         adjust_ff     <= adjust_in;
         level_ff      <= level_in;
         last_count_ff <= last_count_in;
      end
   end

endmodule

`default_nettype wire

### bench/knob_setpoint_controller_core_tb.sv
// Self-checking testbench for the knob setpoint controller core.
`timescale 1ns / 100ps

module knob_setpoint_controller_core_tb;
   import kscc_pkg::*;

   localparam int HIST_W = 8;

   // Tracks debounce, mode and level as the block should, and queues the results
   // that each accepted item ought to produce.
   class setpoint_tracker;
      logic [HIST_W-1:0]  history [2];
      logic               stable [2];
      logic               held [2];
      logic               adjust;
      logic [LEVEL_W-1:0] level;
      logic [COUNT_W-1:0] last_count;
      logic [LEVEL_W-1:0] init_reg;
      logic [LEVEL_W-1:0] max_reg;
      logic [GAIN_W-1:0]  gain_reg;
      logic [COUNT_W-1:0] step_reg;
      rsp_type            pending_results [$];
      int                 errors;

      function new();
         for (int b = 0; b < 2; b++) begin
            history[b] = '1;
            stable[b]  = 1'b1;
            held[b]    = 1'b0;
         end
         adjust     = 1'b0;
         init_reg   = INITIAL_LEVEL_RESET;
         max_reg    = MAX_LEVEL_RESET;
         gain_reg   = OUTPUT_GAIN_RESET;
         step_reg   = FORWARD_STEP_RESET;
         level      = INITIAL_LEVEL_RESET;
         last_count = '0;
         errors     = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_W-1:0] val);
         case (idx)
            CSR_INITIAL_LEVEL: init_reg = val[LEVEL_W-1:0];
            CSR_MAX_LEVEL:     max_reg  = val[LEVEL_W-1:0];
            CSR_OUTPUT_GAIN:   gain_reg = val[GAIN_W-1:0];
            CSR_FORWARD_STEP:  step_reg = val[COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [VALUE_W-1:0] drive_level();
         int product;
         product = int'(level) * int'(gain_reg);
         return (product > int'(VALUE_MAX)) ? VALUE_MAX : product[VALUE_W-1:0];
      endfunction

      function void queue_result(logic kind, logic [VALUE_W-1:0] value);
         rsp_type r;
         r.kind  = kind;
         r.value = value;
         r.last  = 1'b0;
         pending_results.push_back(r);
      endfunction

      function void note_item(logic func, logic pin0, logic pin1, logic [COUNT_W-1:0] count);
         logic [1:0]         pins;
         logic [COUNT_W-1:0] diff;
         int                 n_before;
         n_before = pending_results.size();
         if (func == FUNC_TICK) begin
            pins = {pin1, pin0};
            for (int b = 0; b < 2; b++) begin
               history[b] = {history[b][HIST_W-2:0], pins[b]};
               if (history[b] == '0) stable[b] = 1'b0;
               else if (history[b] == '1) stable[b] = 1'b1;
            end
            // Button 0 is handled first, so its result comes ahead of any save.
            for (int b = 0; b < 2; b++) begin
               if (!stable[b]) begin
                  if (!held[b]) begin
                     held[b] = 1'b1;
                     if (b == 0) begin
                        queue_result(KIND_DRIVE, drive_level());
                     end else begin
                        if (adjust) queue_result(KIND_SAVE, VALUE_W'(level));
                        adjust = !adjust;
                     end
                  end
               end else begin
                  if (held[b] && b == 0) queue_result(KIND_DRIVE, '0);
                  held[b] = 1'b0;
               end
            end
         end else begin
            diff       = count - last_count;
            last_count = count;
            if (adjust) begin
               // A step that would leave 0..max keeps the level, yet still drives.
               if (diff == step_reg) begin
                  if (int'(level) + 1 <= int'(max_reg)) level = level + 1'b1;
               end else begin
                  if (level >= 1 && int'(level) - 1 <= int'(max_reg)) level = level - 1'b1;
               end
               queue_result(KIND_DRIVE, drive_level());
            end
         end
         if (pending_results.size() > n_before) pending_results[$].last = 1'b1;
      endfunction

      function void check_result(logic kind, logic [RSP_DATA_W-1:0] data, logic last);
         rsp_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, got kind %0d value %0d last %0d",
                     $time, kind, data, last);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         if (kind !== want.kind) begin
            $display("%0t: kind mismatch, expected %0d, got %0d", $time, want.kind, kind);
            errors++;
         end
         if (data !== RSP_DATA_W'(want.value)) begin
            $display("%0t: value mismatch, expected %0d, got %0d", $time, want.value, data);
            errors++;
         end
         if (last !== want.last) begin
            $display("%0t: last mismatch, expected %0d, got %0d", $time, want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CSR_A_W-1:0]    csr_addr = '0;
   logic [CSR_W-1:0]      csr_wdata = '0;

   setpoint_tracker tracker = new();
   bit              gaps_on = 1'b1;
   bit              quiet_tail = 1'b0;
   int              items_sent = 0;
   int              stall_left = 0;

   knob_setpoint_controller_core #(
      .HISTORY_BITS(HIST_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // Result side: check every accepted result and stall in random bursts.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_result(rsp_tuser, rsp_tdata, rsp_tlast);
      if (stall_left > 0) stall_left--;
      else if (gaps_on && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 14);
      rsp_tready <= (stall_left == 0);
   end

   task automatic send_item(logic func, logic pin0, logic pin1, logic [COUNT_W-1:0] count);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {6'd0, count, pin1, pin0};
      do @(posedge clock); while (!req_tready);
      tracker.note_item(func, pin0, pin1, count);
      items_sent++;
   endtask

   // Ticks with the chosen buttons at a level (0 or 1) or bouncing (2); others released.
   task automatic hold_pins(bit b0, bit b1, int n, int lvl);
      logic p0, p1;
      repeat (n) begin
         p0 = (lvl == 2) ? 1'($urandom_range(0, 1)) : 1'(lvl);
         p1 = (lvl == 2) ? 1'($urandom_range(0, 1)) : 1'(lvl);
         send_item(FUNC_TICK, b0 ? p0 : 1'b1, b1 ? p1 : 1'b1, 16'($urandom_range(0, 65535)));
      end
   endtask

   // A press and release, now and then held too briefly to pass the debounce.
   task automatic press_gesture(bit b0, bit b1);
      hold_pins(b0, b1, $urandom_range(0, 3), 2);
      hold_pins(b0, b1, ($urandom_range(0, 5) == 0) ? $urandom_range(1, 7)
                                                    : $urandom_range(8, 12), 0);
      hold_pins(b0, b1, $urandom_range(0, 3), 2);
      hold_pins(b0, b1, ($urandom_range(0, 5) == 0) ? $urandom_range(1, 7)
                                                    : $urandom_range(8, 12), 1);
   endtask

   task automatic turn_knob(int up_pct);
      logic [COUNT_W-1:0] diff;
      if ($urandom_range(0, 99) < up_pct) begin
         diff = tracker.step_reg;
      end else begin
         case ($urandom_range(0, 3))
            0: diff = tracker.step_reg + 1'b1;
            1: diff = tracker.step_reg - 1'b1;
            2: diff = '0;
            default: diff = 16'($urandom_range(0, 65535));
         endcase
      end
      send_item(FUNC_ENCODER, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                tracker.last_count + diff);
   endtask

   task automatic run_phase(int n, int up_pct, int enc_pct);
      int first, pick;
      first = items_sent;
      while (items_sent - first < n) begin
         if (!quiet_tail && $urandom_range(0, 29) == 0) gaps_on = ($urandom_range(0, 2) != 0);
         pick = $urandom_range(0, 99);
         // Knob-heavy phases first bring the block into adjust mode.
         if (!tracker.adjust && enc_pct > 50 && pick < 50) begin
            press_gesture(1'b0, 1'b1);
         end else if (pick < enc_pct) begin
            turn_knob(up_pct);
         end else begin
            case ($urandom_range(0, 3))
               0: press_gesture(1'b1, 1'b0);
               1: press_gesture(1'b0, 1'b1);
               2: press_gesture(1'b1, 1'b1);
               default: hold_pins(1'b1, 1'b1, $urandom_range(1, 4), 2);
            endcase
         end
      end
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_W-1:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      tracker.set_register(idx, val);
   endtask

   // Drain the block completely before touching any register.
   task automatic configure(logic [CSR_W-1:0] init_v, logic [CSR_W-1:0] max_v,
                            logic [CSR_W-1:0] gain_v, logic [CSR_W-1:0] step_v);
      req_tvalid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      write_reg(CSR_INITIAL_LEVEL, init_v);
      write_reg(CSR_MAX_LEVEL, max_v);
      write_reg(CSR_OUTPUT_GAIN, gain_v);
      write_reg(CSR_FORWARD_STEP, step_v);
      csr_we <= 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Encoder items outside adjust mode only move the stored count.
      send_item(FUNC_ENCODER, 1'b1, 1'b0, 16'h0000);
      send_item(FUNC_ENCODER, 1'b0, 1'b1, 16'hFFFF);
      // Both buttons pressed together: a drive, and adjust mode comes on silently.
      repeat (8) send_item(FUNC_TICK, 1'b0, 1'b0, 16'hFFFF);
      repeat (8) send_item(FUNC_TICK, 1'b1, 1'b1, 16'h0000);
      // A forward step across the counter wrap, then a backward one.
      send_item(FUNC_ENCODER, 1'b0, 1'b0, 16'h0003);
      send_item(FUNC_ENCODER, 1'b1, 1'b1, 16'h0000);
      // Both pressed again: a drive followed by a save on the same tick.
      repeat (8) send_item(FUNC_TICK, 1'b0, 1'b0, 16'hAAAA);

      run_phase(200, 50, 40);
      // Level sits above a lowered maximum, and a large gain saturates the drive.
      configure(16'hFFFF, 16'hFD2C, 16'd15, 16'd4);
      run_phase(100, 50, 70);
      // Walk the level all the way down to zero.
      configure(16'd0, 16'd1023, 16'd1, 16'd7);
      run_phase(620, 1, 99);
      configure(16'd550, 16'd0, 16'd0, 16'hFFFF);
      run_phase(60, 50, 50);
      configure(16'd1, 16'd1, 16'd8, 16'd1);
      run_phase(80, 70, 60);
      configure(16'd1023, 16'd1023, 16'hFFF8, 16'hFFFF);
      quiet_tail = 1'b1;
      gaps_on    = 1'b0;
      run_phase(100, 60, 50);

      req_tvalid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (tracker.errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
